>>> hw/rtl/assert_macros.svh
// assertion helpers shared by the rtl files
// each helper samples on clk and is disabled while arst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition that must hold at every clock edge
`define FCM_ASSERT(label, cond) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("assertion failed");

// condition that must hold on the cycle after a trigger
`define FCM_ASSERT_NEXT(label, trig, cond) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cond)) \
		else $error("assertion failed");

`endif

>>> hw/rtl/fcm_pkg.sv
`default_nettype none

package fcm_pkg;

	// table entry codes
	localparam logic [15:0] END_MARK  = 16'hFFFF;
	localparam logic [15:0] FREE_MARK = 16'h0000;

	// configuration registers
	localparam int unsigned COUNT_W     = 13;
	localparam logic [COUNT_W-1:0] COUNT_RESET = 13'd4096;
	localparam logic [15:0] BASE_RESET  = 16'd0;

	typedef enum logic {
		CFG_BLOCK_COUNT = 1'b0,
		CFG_BASE_BLOCK  = 1'b1
	} cfg_idx_t;

	// command codes
	typedef enum logic [2:0] {
		CMD_READ  = 3'd0,
		CMD_WRITE = 3'd1,
		CMD_ALLOC = 3'd2,
		CMD_FREE  = 3'd3,
		CMD_LOCATE = 3'd4,
		CMD_COUNT = 3'd5
	} cmd_t;

	// result status codes
	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_NO_FREE = 2'd1,
		ST_RANGE   = 2'd2,
		ST_CHAIN   = 2'd3
	} status_t;

endpackage

`default_nettype wire

>>> hw/rtl/fat_chain_manager_top.sv
//  channel  | direction | handshake          | payload
//  request  | in        | in_valid/in_stall   | cmd, entry_index, entry_value, byte_offset
//  result   | out       | out_valid/out_stall | status, result_value
//  config   | in        | cfg_wr_en           | cfg_index, cfg_data
//
//  after reset a clearing pass writes every table entry, with in_stall high
//  allocate scans the table for the first free entry
//  free chain and locate follow one link at a time, the table read port sets the pace
//  count free reads one entry per cycle
//  a finished result sits in the output register while the next request is taken
`default_nettype none
`include "assert_macros.svh"

module fat_chain_manager_top #(
	parameter int unsigned TABLE_DEPTH = 4096,
	parameter int unsigned BLOCK_SHIFT = 12
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// request channel
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [2:0]  cmd,
	input  wire logic [15:0] entry_index,
	input  wire logic [15:0] entry_value,
	input  wire logic [31:0] byte_offset,
	// result channel
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [1:0]       status,
	output logic [15:0]      result_value,
	// configuration
	input  wire logic        cfg_wr_en,
	input  wire logic        cfg_index,
	input  wire logic [15:0] cfg_data
);

	import fcm_pkg::*;

	localparam int unsigned AW = $clog2(TABLE_DEPTH);
	localparam int unsigned NW = $clog2(TABLE_DEPTH + 1);
	localparam int unsigned LW = 32 - BLOCK_SHIFT;

	typedef enum logic [11:0] {
		S_CLEAR      = 12'b0000_0000_0001,
		S_IDLE       = 12'b0000_0000_0010,
		S_DISPATCH   = 12'b0000_0000_0100,
		S_SCAN       = 12'b0000_0000_1000,
		S_ALLOC_WR   = 12'b0000_0001_0000,
		S_ALLOC_LINK = 12'b0000_0010_0000,
		S_FREE_CHK   = 12'b0000_0100_0000,
		S_FREE_DAT   = 12'b0000_1000_0000,
		S_LOC        = 12'b0001_0000_0000,
		S_LOC_DAT    = 12'b0010_0000_0000,
		S_READ_DAT   = 12'b0100_0000_0000,
		S_EMIT       = 12'b1000_0000_0000
	} state_t;

	state_t               state_q;
	logic [COUNT_W-1:0]   block_count_q;
	logic [15:0]          base_block_q;
	logic [2:0]           cmd_q;
	logic [15:0]          cur_q;
	logic [15:0]          val_q;
	logic [LW-1:0]        links_q;
	logic [NW-1:0]        steps_q;
	logic                 past_q;
	logic [NW-1:0]        scan_q;
	logic                 chk_s1;
	logic [AW-1:0]        addr_s1;
	logic [AW-1:0]        found_q;
	logic [AW-1:0]        clr_q;
	logic [15:0]          cnt_q;
	status_t              pend_status_q;
	logic [15:0]          pend_value_q;
	status_t              status_q;
	logic [15:0]          value_q;
	logic                 out_valid_q;

	logic [NW-1:0]        n;
	logic                 in_range;
	logic                 cur_ok;
	logic                 nxt_ok;
	logic                 loc_past;
	logic [NW-1:0]        loc_limit;
	logic                 out_load;
	logic                 mem_we;
	logic [AW-1:0]        mem_waddr;
	logic [15:0]          mem_wdata;
	logic [AW-1:0]        mem_raddr;
	logic [15:0]          mem_rdata;

	// entries in use, capped at the table depth
	always_comb begin
		if (32'(block_count_q) > TABLE_DEPTH) begin
			n = NW'(TABLE_DEPTH);
		end else begin
			n = NW'(block_count_q);
		end
	end

	// index checks against the entries in use
	assign in_range  = ({1'b0, cur_q} < 17'(n));
	assign cur_ok    = (cur_q != FREE_MARK) && in_range;
	assign nxt_ok    = (mem_rdata != FREE_MARK) && ({1'b0, mem_rdata} < 17'(n));
	assign loc_past  = (32'(links_q) >= (32'(n) - 32'd1));
	assign loc_limit = loc_past ? (n - NW'(1)) : links_q[NW-1:0];

	assign in_stall     = (state_q != S_IDLE);
	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign result_value = value_q;
	assign out_load     = (state_q == S_EMIT) && (!out_valid_q || !out_stall);

	// table port control
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = cur_q[AW-1:0];
		mem_wdata = FREE_MARK;
		mem_raddr = (state_q == S_SCAN) ? scan_q[AW-1:0] : cur_q[AW-1:0];
		unique case (state_q)
			S_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
				mem_wdata = (clr_q == '0) ? END_MARK : FREE_MARK;
			end
			S_DISPATCH: begin
				mem_we    = (cmd_q == CMD_WRITE) && in_range;
				mem_wdata = val_q;
			end
			S_ALLOC_WR: begin
				mem_we    = 1'b1;
				mem_waddr = found_q;
				mem_wdata = END_MARK;
			end
			S_ALLOC_LINK: begin
				mem_we    = 1'b1;
				mem_wdata = 16'(found_q);
			end
			S_FREE_DAT: begin
				mem_we    = (mem_rdata != FREE_MARK);
			end
			default: begin
				mem_we    = 1'b0;
			end
		endcase
	end

	fcm_table #(
		.DEPTH (TABLE_DEPTH),
		.AW    (AW)
	) u_table (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_count_q <= COUNT_RESET;
			base_block_q  <= BASE_RESET;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				CFG_BLOCK_COUNT: block_count_q <= cfg_data[COUNT_W-1:0];
				CFG_BASE_BLOCK:  base_block_q  <= cfg_data;
				default:         base_block_q  <= base_block_q;
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			status_q    <= ST_OK;
			value_q     <= '0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
			status_q    <= pend_status_q;
			value_q     <= pend_value_q;
		end else if (out_valid_q && !out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// command sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_CLEAR;
			clr_q         <= '0;
			cmd_q         <= '0;
			cur_q         <= '0;
			val_q         <= '0;
			links_q       <= '0;
			steps_q       <= '0;
			past_q        <= 1'b0;
			scan_q        <= '0;
			chk_s1        <= 1'b0;
			addr_s1       <= '0;
			found_q       <= '0;
			cnt_q         <= '0;
			pend_status_q <= ST_OK;
			pend_value_q  <= '0;
		end else begin
			unique case (state_q)
				// clearing pass after reset
				S_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (32'(clr_q) == TABLE_DEPTH - 1) begin
						state_q <= S_IDLE;
					end
				end
				// take a request
				S_IDLE: begin
					if (in_valid) begin
						cmd_q   <= cmd;
						cur_q   <= entry_index;
						val_q   <= entry_value;
						links_q <= byte_offset[31:BLOCK_SHIFT];
						state_q <= S_DISPATCH;
					end
				end
				// argument checks and start of each command
				S_DISPATCH: begin
					cnt_q         <= '0;
					scan_q        <= NW'(1);
					chk_s1        <= 1'b0;
					pend_status_q <= ST_OK;
					pend_value_q  <= '0;
					unique case (cmd_q)
						CMD_READ: begin
							if (in_range) begin
								state_q <= S_READ_DAT;
							end else begin
								pend_status_q <= ST_RANGE;
								state_q       <= S_EMIT;
							end
						end
						CMD_WRITE: begin
							if (!in_range) begin
								pend_status_q <= ST_RANGE;
							end
							state_q <= S_EMIT;
						end
						CMD_ALLOC: begin
							if ((cur_q != END_MARK) && !cur_ok) begin
								pend_status_q <= ST_RANGE;
								state_q       <= S_EMIT;
							end else begin
								state_q <= S_SCAN;
							end
						end
						CMD_FREE: begin
							state_q <= S_FREE_CHK;
						end
						CMD_LOCATE: begin
							if (!cur_ok) begin
								pend_status_q <= ST_RANGE;
								state_q       <= S_EMIT;
							end else begin
								past_q  <= loc_past;
								steps_q <= loc_limit;
								state_q <= S_LOC;
							end
						end
						CMD_COUNT: begin
							state_q <= S_SCAN;
						end
						default: begin
							state_q <= S_EMIT;
						end
					endcase
				end
				// one entry read per cycle, checked in the next cycle
				S_SCAN: begin
					if (chk_s1 && (mem_rdata == FREE_MARK) && (cmd_q == CMD_ALLOC)) begin
						found_q <= addr_s1;
						chk_s1  <= 1'b0;
						state_q <= S_ALLOC_WR;
					end else begin
						if (chk_s1 && (mem_rdata == FREE_MARK)) begin
							cnt_q <= cnt_q + 16'd1;
						end
						if (scan_q < n) begin
							chk_s1  <= 1'b1;
							addr_s1 <= scan_q[AW-1:0];
							scan_q  <= scan_q + NW'(1);
						end else begin
							chk_s1 <= 1'b0;
							if (!chk_s1) begin
								if (cmd_q == CMD_ALLOC) begin
									pend_status_q <= ST_NO_FREE;
								end else begin
									pend_value_q <= cnt_q;
								end
								state_q <= S_EMIT;
							end
						end
					end
				end
				// mark the new entry as end of chain
				S_ALLOC_WR: begin
					pend_value_q <= 16'(found_q);
					state_q      <= (cur_q != END_MARK) ? S_ALLOC_LINK : S_EMIT;
				end
				// link the new entry after the tail
				S_ALLOC_LINK: begin
					state_q <= S_EMIT;
				end
				// free chain: check the current link
				S_FREE_CHK: begin
					pend_value_q <= cnt_q;
					if (cur_q == END_MARK) begin
						state_q <= S_EMIT;
					end else if (!cur_ok) begin
						pend_status_q <= ST_RANGE;
						state_q       <= S_EMIT;
					end else begin
						state_q <= S_FREE_DAT;
					end
				end
				// free chain: clear the entry and move on
				S_FREE_DAT: begin
					if (mem_rdata == FREE_MARK) begin
						pend_status_q <= ST_CHAIN;
						state_q       <= S_EMIT;
					end else begin
						cnt_q   <= cnt_q + 16'd1;
						cur_q   <= mem_rdata;
						state_q <= S_FREE_CHK;
					end
				end
				// locate: links left to follow
				S_LOC: begin
					if (steps_q == '0) begin
						if (past_q) begin
							pend_status_q <= ST_CHAIN;
						end else begin
							pend_value_q <= cur_q + base_block_q;
						end
						state_q <= S_EMIT;
					end else begin
						state_q <= S_LOC_DAT;
					end
				end
				// locate: follow one link
				S_LOC_DAT: begin
					if ((mem_rdata == END_MARK) || (mem_rdata == FREE_MARK)) begin
						pend_status_q <= ST_CHAIN;
						state_q       <= S_EMIT;
					end else if (!nxt_ok) begin
						pend_status_q <= ST_RANGE;
						state_q       <= S_EMIT;
					end else begin
						cur_q   <= mem_rdata;
						steps_q <= steps_q - NW'(1);
						state_q <= S_LOC;
					end
				end
				// read data arrives
				S_READ_DAT: begin
					pend_value_q <= mem_rdata;
					state_q      <= S_EMIT;
				end
				// hand the result to the output register
				S_EMIT: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	`FCM_ASSERT(a_state_onehot, $onehot(state_q))
	`FCM_ASSERT_NEXT(a_accept_dispatch, in_valid && !in_stall, state_q == S_DISPATCH)
	`FCM_ASSERT(a_idle_no_write, (state_q != S_IDLE) || !mem_we)
	`FCM_ASSERT_NEXT(a_emit_loads, out_load, out_valid_q && (state_q == S_IDLE))
	`FCM_ASSERT(a_clear_writes, (state_q != S_CLEAR) || mem_we)

endmodule

`default_nettype wire

>>> hw/rtl/fcm_table.sv
`default_nettype none

module fcm_table #(
	parameter int unsigned DEPTH = 4096,
	parameter int unsigned AW    = 12
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [15:0]   wdata,
	input  wire logic [AW-1:0] raddr,
	output logic      [15:0]   rdata
);

	logic [15:0] mem [DEPTH];

	// single write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

>>> test/fat_checker.sv
`timescale 1ns / 1ps

// watches the request, result and config ports, keeps a shadow allocation table
// and compares every result against the oldest predicted answer
module fat_checker
	import fcm_pkg::*;
#(
	parameter int unsigned TABLE_DEPTH = 4096,
	parameter int unsigned BLOCK_SHIFT = 12
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [2:0]  cmd,
	input  logic [15:0] entry_index,
	input  logic [15:0] entry_value,
	input  logic [31:0] byte_offset,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [1:0]  status,
	input  logic [15:0] result_value,
	input  logic        cfg_wr_en,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data,
	output int          fail_count,
	output int          pending,
	output int          results_checked,
	output logic [3:0]  status_seen
);

	typedef struct packed {
		logic [2:0]  op;
		logic [1:0]  st;
		logic [15:0] value;
	} fat_answer_t;

	fat_answer_t answer_q[$];
	logic [15:0] fat_shadow [TABLE_DEPTH];
	logic [12:0] blk_count;
	logic [15:0] base_blk;

	function automatic bit chain_link_ok(input int unsigned idx, input int unsigned n);
		return idx >= 1 && idx < n;
	endfunction

	// apply one request to the shadow table and work out its answer
	task automatic fat_apply(input logic [2:0] op, input logic [15:0] idx,
			input logic [15:0] val, input logic [31:0] off,
			output logic [1:0] st, output logic [15:0] value);
		int unsigned n, i, ix, cur, nxt, hops, limit, total;
		bit done;
		n = (32'(blk_count) > TABLE_DEPTH) ? TABLE_DEPTH : 32'(blk_count);
		st = ST_OK;
		total = 0;
		ix = 32'(idx);
		cur = ix;
		done = 1'b0;
		case (op)
			CMD_READ: begin
				if (ix < n) total = 32'(fat_shadow[ix]);
				else st = ST_RANGE;
			end
			CMD_WRITE: begin
				if (ix < n) fat_shadow[ix] = val;
				else st = ST_RANGE;
			end
			CMD_ALLOC: begin
				if (idx != END_MARK && !chain_link_ok(ix, n)) begin
					st = ST_RANGE;
				end else begin
					// lowest free entry wins, optionally linked after the tail
					st = ST_NO_FREE;
					for (i = 1; i < n && st == ST_NO_FREE; i++) begin
						if (fat_shadow[i] == FREE_MARK) begin
							fat_shadow[i] = END_MARK;
							if (idx != END_MARK) fat_shadow[ix] = 16'(i);
							st = ST_OK;
							total = i;
						end
					end
				end
			end
			CMD_FREE: begin
				// entries cleared before a fault stay cleared
				while (cur != 32'(END_MARK) && !done) begin
					if (!chain_link_ok(cur, n)) begin
						st = ST_RANGE;
						done = 1'b1;
					end else if (fat_shadow[cur] == FREE_MARK) begin
						st = ST_CHAIN;
						done = 1'b1;
					end else begin
						nxt = 32'(fat_shadow[cur]);
						fat_shadow[cur] = FREE_MARK;
						total++;
						cur = nxt;
					end
				end
			end
			CMD_LOCATE: begin
				hops = off >> BLOCK_SHIFT;
				if (!chain_link_ok(cur, n)) begin
					st = ST_RANGE;
				end else begin
					limit = (hops < n - 1) ? hops : n - 1;
					for (i = 0; i < limit && st == ST_OK; i++) begin
						nxt = 32'(fat_shadow[cur]);
						if (nxt == 32'(END_MARK) || nxt == 32'(FREE_MARK)) st = ST_CHAIN;
						else if (!chain_link_ok(nxt, n)) st = ST_RANGE;
						else cur = nxt;
					end
					// a walk this long must have looped
					if (st == ST_OK && hops >= n - 1) st = ST_CHAIN;
					if (st == ST_OK) total = cur + 32'(base_blk);
				end
			end
			CMD_COUNT: begin
				for (i = 1; i < n; i++)
					if (fat_shadow[i] == FREE_MARK) total++;
			end
			default: ;
		endcase
		value = total[15:0];
	endtask

	// config writes, result compare, then prediction for the accepted request
	always @(posedge clk or negedge arst_n) begin : watch
		fat_answer_t want;
		logic [1:0]  st;
		logic [15:0] value;
		if (!arst_n) begin
			for (int i = 0; i < TABLE_DEPTH; i++) fat_shadow[i] = FREE_MARK;
			fat_shadow[0] = END_MARK;
			blk_count = COUNT_RESET;
			base_blk = BASE_RESET;
			answer_q.delete();
			pending = 0;
			fail_count = 0;
			results_checked = 0;
			status_seen = '0;
		end else begin
			if (cfg_wr_en) begin
				case (cfg_idx_t'(cfg_index))
					CFG_BLOCK_COUNT: blk_count = cfg_data[12:0];
					CFG_BASE_BLOCK:  base_blk = cfg_data;
					default: ;
				endcase
			end
			if (out_valid && !out_stall) begin
				results_checked++;
				if (answer_q.size() == 0) begin
					if (fail_count < 10)
						$display("%t: result with no request waiting: %s %0d value %h",
							$realtime, "status", status, result_value);
					fail_count++;
				end else begin
					want = answer_q.pop_front();
					pending--;
					if (status !== want.st || result_value !== want.value) begin
						if (fail_count < 10)
							$display("%t: cmd %0d: expected %0d/%h, got %0d/%h",
								$realtime, want.op, want.st, want.value,
								status, result_value);
						fail_count++;
					end else begin
						status_seen[want.st] = 1'b1;
					end
				end
			end
			if (in_valid && !in_stall) begin
				fat_apply(cmd, entry_index, entry_value, byte_offset, st, value);
				want.op = cmd;
				want.st = st;
				want.value = value;
				answer_q.push_back(want);
				pending++;
			end
		end
	end

endmodule

>>> test/tb.sv
`timescale 1ns / 1ps

module tb;
	import fcm_pkg::*;

	localparam int unsigned TABLE_DEPTH = 4096;
	localparam logic [2:0] CMD_SPARE_A = 3'd6;
	localparam logic [2:0] CMD_SPARE_B = 3'd7;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [2:0]  cmd = '0;
	logic [15:0] entry_index = '0;
	logic [15:0] entry_value = '0;
	logic [31:0] byte_offset = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [1:0]  status;
	logic [15:0] result_value;
	logic        cfg_wr_en = 1'b0;
	logic        cfg_index = 1'b0;
	logic [15:0] cfg_data = '0;

	int          fail_count;
	int          pending;
	int          results_checked;
	logic [3:0]  status_seen;

	int unsigned sender_idle_pct = 0;
	int unsigned recv_stall_pct = 0;
	int unsigned cur_n = TABLE_DEPTH;
	int unsigned sent_total = 0;
	int unsigned settings_run = 1;

	// clock
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	fat_chain_manager_top u_dut (.*);

	fat_checker u_check (.*);

	// result side stalls at random
	always @(negedge clk) begin
		out_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	// one request, held until taken
	task automatic send_req(input logic [2:0] op, input logic [15:0] idx,
			input logic [15:0] val, input logic [31:0] off);
		@(negedge clk);
		while ($urandom_range(99) < sender_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		cmd <= op;
		entry_index <= idx;
		entry_value <= val;
		byte_offset <= off;
		do @(posedge clk); while (in_stall);
		sent_total++;
	endtask

	task automatic cfg_write(input cfg_idx_t idx, input logic [15:0] data);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// drain all outstanding results, then let the block go quiet
	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (16) @(negedge clk);
	endtask

	// write a well-formed chain, walk it, sometimes grow it, then usually free it
	task automatic chain_sequence();
		logic [15:0] chain_idx [6];
		int unsigned len, k, j, from, hops;
		bit dup;
		len = $urandom_range((cur_n - 1 < 6) ? cur_n - 1 : 6, 1);
		for (k = 0; k < len; k++) begin
			do begin
				chain_idx[k] = 16'($urandom_range(cur_n - 1, 1));
				dup = 1'b0;
				for (j = 0; j < k; j++)
					if (chain_idx[j] == chain_idx[k]) dup = 1'b1;
			end while (dup);
		end
		for (k = 0; k < len; k++)
			send_req(CMD_WRITE, chain_idx[k], (k == len - 1) ? END_MARK : chain_idx[k + 1],
				$urandom);
		repeat ($urandom_range(4, 1)) begin
			from = $urandom_range(len - 1);
			hops = $urandom_range(len - from);
			send_req(CMD_LOCATE, chain_idx[from], 16'($urandom),
				(hops << 12) | $urandom_range(4095));
		end
		if ($urandom_range(1))
			send_req(CMD_ALLOC, chain_idx[len - 1], 16'($urandom), $urandom);
		if ($urandom_range(3) == 0)
			send_req(CMD_READ, chain_idx[$urandom_range(len - 1)], 16'($urandom), $urandom);
		if ($urandom_range(9) < 7)
			send_req(CMD_FREE, chain_idx[0], 16'($urandom), $urandom);
	endtask

	// any command, fields mostly near the table size
	task automatic noise_request();
		logic [15:0] idx, val;
		logic [31:0] off;
		int unsigned pick;
		pick = $urandom_range(9);
		if (pick < 7) idx = 16'($urandom_range(cur_n + 1));
		else if (pick < 8) idx = END_MARK;
		else idx = 16'($urandom);
		pick = $urandom_range(9);
		if (pick < 4) val = 16'($urandom);
		else if (pick < 8) val = 16'($urandom_range(cur_n - 1));
		else val = (pick == 8) ? END_MARK : FREE_MARK;
		if ($urandom_range(1)) off = ($urandom_range(cur_n + 1) << 12) | $urandom_range(4095);
		else off = $urandom;
		send_req(3'($urandom_range(7)), idx, val, off);
	endtask

	task automatic run_phase(input logic [15:0] count_word, input logic [15:0] base_word,
			input int unsigned items, input int unsigned s_pct, input int unsigned r_pct);
		int unsigned start;
		settle();
		cfg_write(CFG_BLOCK_COUNT, count_word);
		cfg_write(CFG_BASE_BLOCK, base_word);
		cur_n = 32'(count_word[12:0]);
		if (cur_n > TABLE_DEPTH) cur_n = TABLE_DEPTH;
		sender_idle_pct = s_pct;
		recv_stall_pct = r_pct;
		start = sent_total;
		while (sent_total - start < items) begin
			if (cur_n >= 2 && $urandom_range(99) < 45) chain_sequence();
			else noise_request();
		end
		settings_run++;
	endtask

	// stimulus and verdict
	initial begin
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// edges of the index range on the reset table
		send_req(CMD_READ, 16'd0, 16'd0, 32'd0);
		send_req(CMD_READ, 16'd4095, 16'd0, 32'd0);
		send_req(CMD_READ, 16'd4096, 16'd0, 32'd0);
		send_req(CMD_READ, END_MARK, 16'd0, 32'd0);
		send_req(CMD_WRITE, 16'd4095, END_MARK, 32'd0);
		send_req(CMD_WRITE, 16'd4096, 16'h5A5A, 32'd0);
		// allocate with no tail, good tail, reserved and out of range tails
		send_req(CMD_ALLOC, END_MARK, 16'd0, 32'd0);
		send_req(CMD_ALLOC, 16'd1, 16'd0, 32'd0);
		send_req(CMD_ALLOC, 16'd0, 16'd0, 32'd0);
		send_req(CMD_ALLOC, 16'd4096, 16'd0, 32'd0);
		// walk the two entry chain, past its end and from a bad start
		send_req(CMD_LOCATE, 16'd1, 16'd0, 32'd0);
		send_req(CMD_LOCATE, 16'd1, 16'd0, 32'h0000_1FFF);
		send_req(CMD_LOCATE, 16'd1, 16'd0, 32'h0000_2000);
		send_req(CMD_LOCATE, 16'd1, 16'd0, 32'hFFFF_FFFF);
		send_req(CMD_LOCATE, 16'd0, 16'd0, 32'd0);
		// empty chain, good chain, already freed chain, reserved start
		send_req(CMD_FREE, END_MARK, 16'd0, 32'd0);
		send_req(CMD_FREE, 16'd1, 16'd0, 32'd0);
		send_req(CMD_FREE, 16'd1, 16'd0, 32'd0);
		send_req(CMD_FREE, 16'd0, 16'd0, 32'd0);
		// link leaving the table, then a self loop
		send_req(CMD_WRITE, 16'd3, 16'd5000, 32'd0);
		send_req(CMD_LOCATE, 16'd3, 16'd0, 32'h0000_1000);
		send_req(CMD_FREE, 16'd3, 16'd0, 32'd0);
		send_req(CMD_WRITE, 16'd4, 16'd4, 32'd0);
		send_req(CMD_FREE, 16'd4, 16'd0, 32'd0);
		send_req(CMD_COUNT, 16'd0, 16'd0, 32'd0);
		send_req(CMD_SPARE_A, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
		send_req(CMD_SPARE_B, 16'd1, 16'd1, 32'd1);

		// random traffic over several table sizes and base blocks
		run_phase(16'd16, 16'hFFFF, 250, 0, 0);
		run_phase(16'd1, 16'h0000, 80, 81, 0);
		run_phase(16'd2, 16'h8000, 100, 0, 81);
		run_phase(16'hE028, 16'h1234, 300, 34, 34);
		run_phase(16'd200, 16'hA5A5, 300, 0, 0);
		run_phase(16'h1FFF, 16'h7FFF, 150, 81, 0);
		run_phase(16'd100, 16'h5A5A, 270, 0, 81);
		settle();

		$display("table requests sent: %0d over %0d register settings, results checked: %0d",
			sent_total, settings_run, results_checked);
		$display("status codes returned, one bit per code (chain, range, no free, ok): %b",
			status_seen);
		if (fail_count == 0) begin
			$display("** fat_chain_manager_top: PASSED **");
		end else begin
			$display("%0d mismatches", fail_count);
			$display("** fat_chain_manager_top: FAILED **");
		end
		$finish;
	end

	// watchdog
	initial begin
		#100_000_000;
		$display("timeout with %0d results still owed", pending);
		$display("** fat_chain_manager_top: FAILED **");
		$finish;
	end

endmodule
